>>> rtl/ppcc_pkg.sv
// ============================================================================
// ppcc_pkg: shared types and constants of the point placement checker
// Holds sizing constants, operation and reject codes, register indexes,
// the sequencer state type and the control bundle toward the scan unit.
// ============================================================================
package ppcc_pkg;

  // Capacity of the point store and the largest grid span per axis.
  localparam int MAX_POINTS = 256;
  localparam int MAX_SPAN   = 8;

  localparam int AW  = $clog2(MAX_POINTS);      // store address width
  localparam int CW  = $clog2(MAX_POINTS + 1);  // fill count width
  localparam int SPW = $clog2(MAX_SPAN + 1);    // clamped span width

  localparam int CRDW = 16;                     // Q3.12 coordinate width
  localparam int RW   = 13;                     // item radius width
  localparam int NRW  = 14;                     // nest radius width
  localparam int STW  = RW + 2;                 // grid step (3r) width
  localparam int NLW  = NRW + 1;                // R + r width
  localparam int LW   = 2 * NLW;                // squared limit width

  // Grid coordinates and extents reach x + 2r + 3r*span, well within 21 bits.
  localparam int GW   = 21;
  localparam int DW   = GW + 1;                 // coordinate difference width
  localparam int SQW  = 2 * DW;                 // squared difference width

  localparam int PW   = 2 * CRDW;               // stored point width

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLACE = 2'd1,
    OP_CHECK = 2'd2
  } ppcc_op_t;

  typedef enum logic [2:0] {
    RC_NONE   = 3'd0,
    RC_BOUNDS = 3'd1,
    RC_ITEM   = 3'd2,
    RC_NEST   = 3'd3,
    RC_FULL   = 3'd4
  } ppcc_rc_t;

  typedef enum logic [2:0] {
    CFG_AREA_X_MIN = 3'd0,
    CFG_AREA_X_MAX = 3'd1,
    CFG_AREA_Y_MIN = 3'd2,
    CFG_AREA_Y_MAX = 3'd3,
    CFG_ITEM_RAD   = 3'd4,
    CFG_NEST_RAD   = 3'd5,
    CFG_NEST_X     = 3'd6,
    CFG_NEST_Y     = 3'd7
  } ppcc_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_BOUND,
    S_GRID,
    S_ITEMS,
    S_NEST,
    S_WAIT,
    S_DONE
  } ppcc_state_t;

  // Sequencer to scan unit.
  typedef struct packed {
    logic          clr;      // clear the sticky hit flags
    logic          issue;    // launch one distance test
    logic          is_nest;  // test against the nest instead of a stored point
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [PW-1:0] wdata;
  } ppcc_scan_ctl_t;

  // Scan unit to sequencer.
  typedef struct packed {
    logic pipe_busy;
    logic item_hit;
    logic nest_hit;
  } ppcc_scan_stat_t;

  // Span values of zero count as one; values above MAX_SPAN saturate.
  function automatic logic [SPW-1:0] clamp_span(input logic [3:0] s);
    logic [SPW-1:0] res;
    if (s == 4'd0) begin
      res = SPW'(1);
    end else if (int'(s) > MAX_SPAN) begin
      res = SPW'(MAX_SPAN);
    end else begin
      res = SPW'(s);
    end
    return res;
  endfunction

endpackage

>>> rtl/ppcc_scan.sv
// ============================================================================
// ppcc_scan: point store and distance test pipeline
// Holds the stored points in a synchronous memory and tests the current grid
// point against one stored point (or the nest) per cycle, collecting hits.
// ============================================================================
module ppcc_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppcc_pkg::ppcc_scan_ctl_t       ctl,
  input  logic signed [ppcc_pkg::GW-1:0] grid_x,
  input  logic signed [ppcc_pkg::GW-1:0] grid_y,
  input  logic signed [ppcc_pkg::CRDW-1:0] nest_x,
  input  logic signed [ppcc_pkg::CRDW-1:0] nest_y,
  input  logic [ppcc_pkg::LW-1:0]        item_lim2,
  input  logic [ppcc_pkg::LW-1:0]        nest_lim2,
  output ppcc_pkg::ppcc_scan_stat_t      stat
);

  logic [ppcc_pkg::PW-1:0] mem [ppcc_pkg::MAX_POINTS];
  logic [ppcc_pkg::PW-1:0] rd_data_r;

  logic v1_r, v2_r, v3_r;
  logic nest1_r, nest2_r, nest3_r;

  logic signed [ppcc_pkg::CRDW-1:0] sel_x, sel_y;
  logic signed [ppcc_pkg::DW-1:0]   dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [ppcc_pkg::SQW-1:0]  sqx_nxt, sqy_nxt;
  logic [ppcc_pkg::SQW-1:0]         sqx_r, sqy_r;
  logic [ppcc_pkg::SQW:0]           dist2;
  logic [ppcc_pkg::SQW:0]           lim2;
  logic                             hit;
  logic                             item_hit_r, item_hit_nxt;
  logic                             nest_hit_r, nest_hit_nxt;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rd_data_r <= mem[ctl.raddr];
  end

  // Stage 1: pick the reference point and take the differences.
  always_comb begin
    sel_x  = nest1_r ? nest_x : $signed(rd_data_r[ppcc_pkg::CRDW-1:0]);
    sel_y  = nest1_r ? nest_y : $signed(rd_data_r[ppcc_pkg::PW-1:ppcc_pkg::CRDW]);
    dx_nxt = ppcc_pkg::DW'(grid_x) - ppcc_pkg::DW'(sel_x);
    dy_nxt = ppcc_pkg::DW'(grid_y) - ppcc_pkg::DW'(sel_y);
  end

  // Stage 2: squares (operands are sign extended to the product width).
  always_comb begin
    sqx_nxt = dx_r * dx_r;
    sqy_nxt = dy_r * dy_r;
  end

  // Stage 3: sum and compare against the limit that belongs to the test.
  always_comb begin
    dist2 = {1'b0, sqx_r} + {1'b0, sqy_r};
    lim2  = nest3_r ? (ppcc_pkg::SQW+1)'(nest_lim2) : (ppcc_pkg::SQW+1)'(item_lim2);
    hit   = dist2 < lim2;
    item_hit_nxt = item_hit_r;
    nest_hit_nxt = nest_hit_r;
    if (ctl.clr) begin
      item_hit_nxt = 1'b0;
      nest_hit_nxt = 1'b0;
    end else if (v3_r && hit) begin
      if (nest3_r) begin
        nest_hit_nxt = 1'b1;
      end else begin
        item_hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      item_hit_r <= 1'b0;
      nest_hit_r <= 1'b0;
    end else begin
      v1_r       <= ctl.issue;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      item_hit_r <= item_hit_nxt;
      nest_hit_r <= nest_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nest1_r <= ctl.is_nest;
    nest2_r <= nest1_r;
    nest3_r <= nest2_r;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    sqx_r   <= $unsigned(sqx_nxt);
    sqy_r   <= $unsigned(sqy_nxt);
  end

  assign stat.pipe_busy = v1_r | v2_r | v3_r;
  assign stat.item_hit  = item_hit_r;
  assign stat.nest_hit  = nest_hit_r;

endmodule

>>> rtl/point_placement_collision_checker_core.sv
// ============================================================================
// point_placement_collision_checker_core: placement decision for points
// Checks a candidate point and its grid span against the area bounds, the
// stored points and the nest, and optionally stores the candidate.
// ============================================================================
// Usage:
// A request is taken on a rising edge where start is high and busy is low;
// in_operation selects clear (0), check and place (1) or check only (2 and 3).
// Exactly one result follows per request: out_strobe is high for one cycle
// with out_accepted, out_reject_code and out_stored_count valid in that cycle.
// The receiver cannot stall the block; it must take the result when strobed.
// busy stays high from the cycle after the request up to and including the
// strobe cycle, so one request is worked on at a time.
// Sequence: a clear strobes in the cycle after the request. A check first
// computes the extents, then runs the bounds test, then for each of the L*W
// grid points clears the hit flags, tests one stored point per cycle through
// the single memory read port, tests the nest and waits for the distance
// pipeline to drain; then the strobe follows. A bounds failure strobes
// without a scan. An item or nest hit ends the scan at the grid point where
// it occurs.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data). It is to
// be written only while the block is idle; the block does not enforce this.
// Reset clears the point count and loads the register defaults; the memory
// content is not cleared, since only entries below the count are ever tested.
// ============================================================================
module point_placement_collision_checker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic signed [ppcc_pkg::CRDW-1:0] in_pos_x,
  input  logic signed [ppcc_pkg::CRDW-1:0] in_pos_y,
  input  logic [3:0]                      in_span_length,
  input  logic [3:0]                      in_span_width,
  // result channel
  output logic                            out_strobe,
  output logic                            out_accepted,
  output logic [2:0]                      out_reject_code,
  output logic [ppcc_pkg::CW-1:0]         out_stored_count,
  // configuration
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [15:0]                     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [ppcc_pkg::CRDW-1:0] area_x_min_r, area_x_max_r;
  logic signed [ppcc_pkg::CRDW-1:0] area_y_min_r, area_y_max_r;
  logic [ppcc_pkg::RW-1:0]          item_radius_r;
  logic [ppcc_pkg::NRW-1:0]         nest_radius_r;
  logic signed [ppcc_pkg::CRDW-1:0] nest_x_r, nest_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_x_min_r  <= -16'sd9216;
      area_x_max_r  <= 16'sd9216;
      area_y_min_r  <= -16'sd9216;
      area_y_max_r  <= 16'sd9216;
      item_radius_r <= ppcc_pkg::RW'(205);
      nest_radius_r <= ppcc_pkg::NRW'(1024);
      nest_x_r      <= '0;
      nest_y_r      <= '0;
    end else if (cfg_we) begin
      case (ppcc_pkg::ppcc_cfg_t'(cfg_index))
        ppcc_pkg::CFG_AREA_X_MIN: area_x_min_r  <= $signed(cfg_data);
        ppcc_pkg::CFG_AREA_X_MAX: area_x_max_r  <= $signed(cfg_data);
        ppcc_pkg::CFG_AREA_Y_MIN: area_y_min_r  <= $signed(cfg_data);
        ppcc_pkg::CFG_AREA_Y_MAX: area_y_max_r  <= $signed(cfg_data);
        ppcc_pkg::CFG_ITEM_RAD:   item_radius_r <= cfg_data[ppcc_pkg::RW-1:0];
        ppcc_pkg::CFG_NEST_RAD:   nest_radius_r <= cfg_data[ppcc_pkg::NRW-1:0];
        ppcc_pkg::CFG_NEST_X:     nest_x_r      <= $signed(cfg_data);
        ppcc_pkg::CFG_NEST_Y:     nest_y_r      <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and working registers
  // --------------------------------------------------------------------------
  ppcc_pkg::ppcc_state_t state_r, state_nxt;

  logic [ppcc_pkg::CW-1:0]          count_r, count_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic signed [ppcc_pkg::CRDW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [ppcc_pkg::SPW-1:0]         len_r, len_nxt, wid_r, wid_nxt;
  logic [ppcc_pkg::SPW-1:0]         row_r, row_nxt, col_r, col_nxt;
  logic [ppcc_pkg::AW-1:0]          idx_r, idx_nxt;
  logic signed [ppcc_pkg::GW-1:0]   xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic signed [ppcc_pkg::GW-1:0]   ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic signed [ppcc_pkg::GW-1:0]   gx_r, gx_nxt, gy_r, gy_nxt;
  logic [ppcc_pkg::STW-1:0]         step_r, step_nxt;
  logic [ppcc_pkg::LW-1:0]          item_lim2_r, item_lim2_nxt;
  logic [ppcc_pkg::LW-1:0]          nest_lim2_r, nest_lim2_nxt;
  logic                             acc_r, acc_nxt;
  ppcc_pkg::ppcc_rc_t               code_r, code_nxt;

  ppcc_pkg::ppcc_scan_ctl_t  scan_ctl;
  ppcc_pkg::ppcc_scan_stat_t scan_stat;

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  logic [ppcc_pkg::RW:0]              r2;          // 2r
  logic [ppcc_pkg::NLW-1:0]           nest_lim;    // R + r
  logic [ppcc_pkg::SPW+1:0]           wid3, len3;  // 3 * span
  logic [ppcc_pkg::RW+ppcc_pkg::SPW+1:0] xspan, yspan;
  logic signed [ppcc_pkg::GW-1:0]     r2_s, xspan_s, yspan_s, step_s;
  logic signed [ppcc_pkg::GW-1:0]     px_g, py_g;
  logic                               bound_fail;
  logic                               last_item, last_col, last_row;
  logic                               store_full;
  logic                               req_take;

  assign req_take = start && (state_r == ppcc_pkg::S_IDLE);

  always_comb begin
    r2       = {item_radius_r, 1'b0};
    nest_lim = ppcc_pkg::NLW'(nest_radius_r) + ppcc_pkg::NLW'(item_radius_r);
    wid3     = (ppcc_pkg::SPW+2)'(wid_r) + ((ppcc_pkg::SPW+2)'(wid_r) << 1);
    len3     = (ppcc_pkg::SPW+2)'(len_r) + ((ppcc_pkg::SPW+2)'(len_r) << 1);
    // r * 3 * span: the whole span extent, including the margin step.
    xspan    = item_radius_r * wid3;
    yspan    = item_radius_r * len3;
    r2_s     = ppcc_pkg::GW'($signed({1'b0, r2}));
    xspan_s  = ppcc_pkg::GW'($signed({1'b0, xspan}));
    yspan_s  = ppcc_pkg::GW'($signed({1'b0, yspan}));
    step_s   = ppcc_pkg::GW'($signed({1'b0, step_r}));
    px_g     = ppcc_pkg::GW'(px_r);
    py_g     = ppcc_pkg::GW'(py_r);

    // x - r < xmin + r is x - 2r < xmin; the upper test folds the same way.
    bound_fail = (xlo_r < ppcc_pkg::GW'(area_x_min_r)) ||
                 (xhi_r > ppcc_pkg::GW'(area_x_max_r)) ||
                 (ylo_r < ppcc_pkg::GW'(area_y_min_r)) ||
                 (yhi_r > ppcc_pkg::GW'(area_y_max_r));

    last_item  = (ppcc_pkg::CW'(idx_r) == (count_r - ppcc_pkg::CW'(1)));
    last_col   = (col_r == (wid_r - ppcc_pkg::SPW'(1)));
    last_row   = (row_r == (len_r - ppcc_pkg::SPW'(1)));
    store_full = (count_r == ppcc_pkg::CW'(ppcc_pkg::MAX_POINTS));
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppcc_pkg::S_IDLE: begin
        if (req_take) begin
          if (in_operation == ppcc_pkg::OP_CLEAR) begin
            state_nxt = ppcc_pkg::S_DONE;
          end else begin
            state_nxt = ppcc_pkg::S_PREP;
          end
        end
      end
      ppcc_pkg::S_PREP: begin
        state_nxt = ppcc_pkg::S_BOUND;
      end
      ppcc_pkg::S_BOUND: begin
        state_nxt = bound_fail ? ppcc_pkg::S_DONE : ppcc_pkg::S_GRID;
      end
      ppcc_pkg::S_GRID: begin
        state_nxt = (count_r == '0) ? ppcc_pkg::S_NEST : ppcc_pkg::S_ITEMS;
      end
      ppcc_pkg::S_ITEMS: begin
        if (last_item) begin
          state_nxt = ppcc_pkg::S_NEST;
        end
      end
      ppcc_pkg::S_NEST: begin
        state_nxt = ppcc_pkg::S_WAIT;
      end
      ppcc_pkg::S_WAIT: begin
        if (!scan_stat.pipe_busy) begin
          if (scan_stat.item_hit || scan_stat.nest_hit || (last_col && last_row)) begin
            state_nxt = ppcc_pkg::S_DONE;
          end else begin
            state_nxt = ppcc_pkg::S_GRID;
          end
        end
      end
      ppcc_pkg::S_DONE: begin
        state_nxt = ppcc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ppcc_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt     = count_r;
    op_nxt        = op_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    len_nxt       = len_r;
    wid_nxt       = wid_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    step_nxt      = step_r;
    item_lim2_nxt = item_lim2_r;
    nest_lim2_nxt = nest_lim2_r;
    acc_nxt       = acc_r;
    code_nxt      = code_r;

    scan_ctl         = '0;
    scan_ctl.raddr   = idx_r;
    scan_ctl.waddr   = count_r[ppcc_pkg::AW-1:0];
    scan_ctl.wdata   = {py_r, px_r};

    busy       = (state_r != ppcc_pkg::S_IDLE);
    out_strobe = (state_r == ppcc_pkg::S_DONE);

    case (state_r)
      ppcc_pkg::S_IDLE: begin
        if (req_take) begin
          op_nxt  = in_operation;
          px_nxt  = in_pos_x;
          py_nxt  = in_pos_y;
          len_nxt = ppcc_pkg::clamp_span(in_span_length);
          wid_nxt = ppcc_pkg::clamp_span(in_span_width);
          if (in_operation == ppcc_pkg::OP_CLEAR) begin
            count_nxt = '0;
            acc_nxt   = 1'b0;
            code_nxt  = ppcc_pkg::RC_NONE;
          end
        end
      end
      ppcc_pkg::S_PREP: begin
        // Span extents, grid step and both squared limits.
        xlo_nxt       = px_g - r2_s;
        ylo_nxt       = py_g - r2_s;
        xhi_nxt       = px_g + r2_s + xspan_s;
        yhi_nxt       = py_g + r2_s + yspan_s;
        step_nxt      = ppcc_pkg::STW'(item_radius_r) + ppcc_pkg::STW'(r2);
        item_lim2_nxt = ppcc_pkg::LW'(r2 * r2);
        nest_lim2_nxt = nest_lim * nest_lim;
      end
      ppcc_pkg::S_BOUND: begin
        if (bound_fail) begin
          acc_nxt  = 1'b0;
          code_nxt = ppcc_pkg::RC_BOUNDS;
        end else begin
          gx_nxt  = px_g;
          gy_nxt  = py_g;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      ppcc_pkg::S_GRID: begin
        scan_ctl.clr = 1'b1;
        idx_nxt      = '0;
      end
      ppcc_pkg::S_ITEMS: begin
        scan_ctl.issue = 1'b1;
        idx_nxt        = idx_r + ppcc_pkg::AW'(1);
      end
      ppcc_pkg::S_NEST: begin
        scan_ctl.issue   = 1'b1;
        scan_ctl.is_nest = 1'b1;
      end
      ppcc_pkg::S_WAIT: begin
        if (!scan_stat.pipe_busy) begin
          // Stored points take precedence over the nest at one grid point.
          if (scan_stat.item_hit) begin
            acc_nxt  = 1'b0;
            code_nxt = ppcc_pkg::RC_ITEM;
          end else if (scan_stat.nest_hit) begin
            acc_nxt  = 1'b0;
            code_nxt = ppcc_pkg::RC_NEST;
          end else if (last_col && last_row) begin
            code_nxt = ppcc_pkg::RC_NONE;
            if (op_r == ppcc_pkg::OP_PLACE) begin
              if (store_full) begin
                acc_nxt  = 1'b0;
                code_nxt = ppcc_pkg::RC_FULL;
              end else begin
                scan_ctl.we = 1'b1;
                count_nxt   = count_r + ppcc_pkg::CW'(1);
                acc_nxt     = 1'b1;
              end
            end else begin
              acc_nxt = 1'b1;
            end
          end else if (last_col) begin
            row_nxt = row_r + ppcc_pkg::SPW'(1);
            col_nxt = '0;
            gx_nxt  = px_g;
            gy_nxt  = gy_r + step_s;
          end else begin
            col_nxt = col_r + ppcc_pkg::SPW'(1);
            gx_nxt  = gx_r + step_s;
          end
        end
      end
      ppcc_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppcc_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    len_r       <= len_nxt;
    wid_r       <= wid_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    idx_r       <= idx_nxt;
    xlo_r       <= xlo_nxt;
    xhi_r       <= xhi_nxt;
    ylo_r       <= ylo_nxt;
    yhi_r       <= yhi_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    step_r      <= step_nxt;
    item_lim2_r <= item_lim2_nxt;
    nest_lim2_r <= nest_lim2_nxt;
    acc_r       <= acc_nxt;
    code_r      <= code_nxt;
  end

  // --------------------------------------------------------------------------
  // Point store and distance pipeline. The store is written only at the end
  // of a place request and its entries are tested only in later requests, so
  // a test never uses an entry while it is being written.
  // --------------------------------------------------------------------------
  ppcc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .grid_x    (gx_r),
    .grid_y    (gy_r),
    .nest_x    (nest_x_r),
    .nest_y    (nest_y_r),
    .item_lim2 (item_lim2_r),
    .nest_lim2 (nest_lim2_r),
    .stat      (scan_stat)
  );

  assign out_accepted     = acc_r;
  assign out_reject_code  = code_r;
  assign out_stored_count = count_r;

endmodule

>>> rtl/ppcc_checker.sv
// ============================================================================
// ppcc_checker: port level checks of the placement checker
// Watches the request and result ports over time and flags misbehavior.
// ============================================================================
module ppcc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_operation,
  input logic                      out_strobe,
  input logic                      out_accepted,
  input logic [2:0]                out_reject_code,
  input logic [ppcc_pkg::CW-1:0]   out_stored_count
);

  // A taken request keeps the block busy until its result.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // A clear answers in the next cycle with an empty store.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == ppcc_pkg::OP_CLEAR)) |=>
      (out_strobe && (out_stored_count == '0) && !out_accepted))
    else $error("clear result wrong");

  // An accepted result carries no reject code.
  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_accepted) |-> (out_reject_code == ppcc_pkg::RC_NONE))
    else $error("accepted result with reject code");

  // A result is strobed once and the block is free right after it.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe not single");

endmodule

bind point_placement_collision_checker_core ppcc_checker u_ppcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_strobe       (out_strobe),
  .out_accepted     (out_accepted),
  .out_reject_code  (out_reject_code),
  .out_stored_count (out_stored_count)
);
